FILE: hw/rtl/mrc_pkg.sv
// Shared constants and the pipeline word type of the rank/coordinate converter.
package mrc_pkg;

  localparam int MAX_DIMS_DEF  = 4;
  localparam int NUM_COORD     = 4;
  localparam int COORD_W       = 8;
  localparam int RANK_W        = 32;
  localparam int BITS_PER_STEP = 4;
  localparam int SUB_STEPS     = RANK_W / BITS_PER_STEP;

  localparam logic [2:0] REG_NUM_DIMS  = 3'd0;
  localparam logic [2:0] REG_SIZE_DIM0 = 3'd1;
  localparam logic [2:0] REG_SIZE_DIM1 = 3'd2;
  localparam logic [2:0] REG_SIZE_DIM2 = 3'd3;
  localparam logic [2:0] REG_SIZE_DIM3 = 3'd4;
  localparam logic [2:0] REG_DIM_ORDER = 3'd5;

  localparam logic ACT_TO_COORD = 1'b0;
  localparam logic ACT_TO_RANK  = 1'b1;

  typedef logic [NUM_COORD-1:0][COORD_W-1:0] coord_vec_t;

  // One word in flight: n is the running quotient (to-coord) or accumulator
  // (to-rank); rem is the partial remainder of the current division.
  typedef struct packed {
    logic               act;
    logic [RANK_W-1:0]  n;
    logic [COORD_W-1:0] rem;
    coord_vec_t         coord;
  } stage_t;

endpackage

FILE: hw/rtl/mixed_radix_rank_coord_convert_top.sv
// Top level: pipelined mixed-radix rank <-> grid coordinate converter with APB registers.
// Throughput: one word per cycle while the output is not stalled; each dimension takes 8 stages
// of 4 restoring division bits (to-coord), and to-rank does its multiply-accumulate
// in the first of them. Stalls collapse bubbles stage by stage; in_tready stays high
// while any stage is free.
// Reset (rst_n, synchronous, active low) clears all valid bits and loads the registers
// with num_dims 4, every extent 1 and the identity dimension order.
module mixed_radix_rank_coord_convert_top #(
  parameter int MAX_DIMS = mrc_pkg::MAX_DIMS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input words
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // rank_in[31:0], coord_in_0..coord_in_3 (8 bits each)
  input  logic        in_tuser,   // action
  // result words
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // rank_out[31:0], coord_out_0..coord_out_3 (8 bits each)
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import mrc_pkg::*;

  localparam int NSTG = MAX_DIMS * SUB_STEPS;

  // ---------------- configuration registers ----------------
  logic [2:0]                          num_dims_r;
  logic [NUM_COORD-1:0][COORD_W-1:0]   size_r;
  logic [7:0]                          order_r;
  logic [2:0]                          reg_idx;
  logic                                cfg_wr;

  assign reg_idx    = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_dims_r <= 3'd4;
      size_r     <= {NUM_COORD{8'd1}};
      order_r    <= 8'd228;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_NUM_DIMS:  num_dims_r <= cfg_pwdata[2:0];
        REG_SIZE_DIM0: size_r[0]  <= cfg_pwdata[7:0];
        REG_SIZE_DIM1: size_r[1]  <= cfg_pwdata[7:0];
        REG_SIZE_DIM2: size_r[2]  <= cfg_pwdata[7:0];
        REG_SIZE_DIM3: size_r[3]  <= cfg_pwdata[7:0];
        REG_DIM_ORDER: order_r    <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_NUM_DIMS:  cfg_prdata = {29'd0, num_dims_r};
      REG_SIZE_DIM0: cfg_prdata = {24'd0, size_r[0]};
      REG_SIZE_DIM1: cfg_prdata = {24'd0, size_r[1]};
      REG_SIZE_DIM2: cfg_prdata = {24'd0, size_r[2]};
      REG_SIZE_DIM3: cfg_prdata = {24'd0, size_r[3]};
      REG_DIM_ORDER: cfg_prdata = {24'd0, order_r};
      default:       cfg_prdata = 32'd0;
    endcase
  end

  // Dimensions walked: clamp to MAX_DIMS. Extent zero acts as one.
  logic [2:0]                        nd;
  logic [NUM_COORD-1:0][COORD_W-1:0] ext;

  assign nd = (num_dims_r > 3'(MAX_DIMS)) ? 3'(MAX_DIMS) : num_dims_r;

  always_comb begin
    for (int k = 0; k < NUM_COORD; k++) begin
      ext[k] = (size_r[k] == '0) ? 8'd1 : size_r[k];
    end
  end

  // ---------------- pipeline ----------------
  // stg_r[0] is the input register, stg_r[NSTG] the output register.
  stage_t [NSTG:0] stg_r;
  stage_t [NSTG:1] stg_nxt;
  logic   [NSTG:0] vld_r;
  logic   [NSTG:0] en;

  // A stage may load when it is empty or its contents move on this cycle.
  assign en[NSTG] = !vld_r[NSTG] || out_tready;
  genvar g;
  generate
    for (g = 0; g < NSTG; g++) begin : g_en
      assign en[g] = !vld_r[g] || en[g+1];
    end
  endgenerate
  assign in_tready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) vld_r[0] <= in_tvalid;
      for (int t = 1; t <= NSTG; t++) begin
        if (en[t]) vld_r[t] <= vld_r[t-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      stg_r[0].act <= in_tuser;
      stg_r[0].rem <= '0;
      if (in_tuser == ACT_TO_RANK) begin
        stg_r[0].n     <= '0;
        stg_r[0].coord <= in_tdata[63:32];
      end else begin
        stg_r[0].n     <= in_tdata[31:0];
        stg_r[0].coord <= '0;
      end
    end
    for (int t = 1; t <= NSTG; t++) begin
      if (en[t]) stg_r[t] <= stg_nxt[t];
    end
  end

  // Stage t belongs to dimension step J; its first sub-step does the to-rank
  // multiply-accumulate, every sub-step does four to-coord division bits, the last
  // sub-step stores the remainder as a coordinate.
  generate
    for (g = 0; g < NSTG; g++) begin : g_stg
      localparam int  J     = g / SUB_STEPS;
      localparam bit  FIRST = (g % SUB_STEPS) == 0;
      localparam bit  LAST  = (g % SUB_STEPS) == (SUB_STEPS - 1);

      logic [1:0]         kdiv;
      logic [1:0]         kmac;
      logic               live;

      assign live = 3'(J) < nd;
      assign kdiv = order_r[2*(J%4) +: 2];
      assign kmac = order_r[2*((nd - 3'(J) - 3'd1) & 3'd3) +: 2];

      always_comb begin
        stage_t         s;
        logic [8:0]     r9;
        logic [COORD_W-1:0] dv;
        s  = stg_r[g];
        dv = ext[kdiv];
        r9 = '0;
        if (FIRST) s.rem = '0;
        if (live) begin
          if (s.act == ACT_TO_RANK) begin
            if (FIRST) begin
              s.n = s.n * {24'd0, ext[kmac]} + {24'd0, s.coord[kmac]};
            end
          end else begin
            for (int b = 0; b < BITS_PER_STEP; b++) begin
              r9 = {s.rem, s.n[RANK_W-1]};
              if (r9 >= {1'b0, dv}) begin
                s.rem = 8'(r9 - {1'b0, dv});
                s.n   = {s.n[RANK_W-2:0], 1'b1};
              end else begin
                s.rem = r9[7:0];
                s.n   = {s.n[RANK_W-2:0], 1'b0};
              end
            end
            if (LAST) s.coord[kdiv] = s.rem;
          end
        end
        stg_nxt[g+1] = s;
      end
    end
  endgenerate

  // Hand out the output register; zero the fields the action does not produce.
  assign out_tvalid = vld_r[NSTG];
  assign out_tdata  = (stg_r[NSTG].act == ACT_TO_RANK) ? {32'd0, stg_r[NSTG].n}
                                                       : {stg_r[NSTG].coord, 32'd0};

endmodule

FILE: tb/sv/mixed_radix_rank_coord_convert_top_tb.sv
// Testbench for the mixed-radix rank/coordinate converter: directed and random stream traffic
// checked against an in-bench conversion model across several grid settings.
module mixed_radix_rank_coord_convert_top_tb;
  import mrc_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int LATENCY        = 40;

  // Expected result word of one conversion.
  typedef struct packed {
    logic [RANK_W-1:0] rank;
    coord_vec_t        coord;
  } conv_word_t;

  // Scoreboard: holds the grid settings and the queue of pending conversions.
  class conv_scoreboard;
    logic [2:0]         n_dims;
    logic [7:0]         extent[4];
    logic [7:0]         order;
    conv_word_t         pending[$];
    int                 errors;

    function void reset_grid();
      n_dims = 3'd4;
      foreach (extent[k]) extent[k] = 8'd1;
      order  = 8'd228;
      errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        REG_NUM_DIMS:  n_dims = val[2:0];
        REG_DIM_ORDER: order = val[7:0];
        REG_SIZE_DIM0, REG_SIZE_DIM1, REG_SIZE_DIM2, REG_SIZE_DIM3:
          extent[idx - REG_SIZE_DIM0] = val[7:0];
        default: ;
      endcase
    endfunction

    function void note_input(logic act, logic [63:0] data);
      conv_word_t w;
      int         nd;
      logic [1:0] k;
      logic [31:0] n, ext;
      w  = '0;
      nd = (n_dims > 4) ? 4 : n_dims;
      if (act == ACT_TO_COORD) begin
        n = data[31:0];
        for (int i = 0; i < nd; i++) begin
          k   = order[2*i +: 2];
          ext = (extent[k] == 0) ? 32'd1 : {24'd0, extent[k]};
          w.coord[k] = 8'(n % ext);
          n   = n / ext;
        end
      end else begin
        for (int i = nd; i > 0; i--) begin
          k   = order[2*(i-1) +: 2];
          ext = (extent[k] == 0) ? 32'd1 : {24'd0, extent[k]};
          w.rank = w.rank * ext + {24'd0, data[32 + 8*k +: 8]};
        end
      end
      pending.push_back(w);
    endfunction

    function void check_result(logic [63:0] data);
      conv_word_t exp_w;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, data);
        errors++;
        return;
      end
      exp_w = pending.pop_front();
      if (data[31:0] !== exp_w.rank) begin
        $display("%0t: rank_out expected %0d actual %0d", $time, exp_w.rank, data[31:0]);
        errors++;
      end
      for (int c = 0; c < NUM_COORD; c++)
        if (data[32 + 8*c +: 8] !== exp_w.coord[c]) begin
          $display("%0t: coord_out_%0d expected %0d actual %0d", $time, c,
                   exp_w.coord[c], data[32 + 8*c +: 8]);
          errors++;
        end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;   // rank_in[31:0], coord_in_0..coord_in_3 (8 bits each)
  logic        in_tuser;   // action
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;  // rank_out[31:0], coord_out_0..coord_out_3 (8 bits each)
  logic        cfg_psel, cfg_penable, cfg_pwrite;
  logic [4:0]  cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;
  logic        cfg_pready;

  conv_scoreboard grid_sb;
  bit             idle_en;     // random idling on both sides when set
  bit             sink_done;
  int             quiet_cycles;

  mixed_radix_rank_coord_convert_top dut (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Note accepted words and check results at the rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) grid_sb.note_input(in_tuser, in_tdata);
      if (out_tvalid && out_tready) grid_sb.check_result(out_tdata);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel)
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stall the result side at random; drop the stall during quiet stretches.
  always @(negedge clk) begin
    if (sink_done) out_tready <= 1'b1;
    else out_tready <= !idle_en || ($urandom_range(99) >= 34);
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk) begin
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    cfg_penable <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    grid_sb.write_reg(idx, val);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // Drive one word; hold it until accepted, with a random gap before it.
  task automatic send_word(logic act, logic [63:0] data);
    @(negedge clk);
    while (idle_en && $urandom_range(99) < 34) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= data;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (grid_sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic set_grid(int nd, int e0, int e1, int e2, int e3, logic [7:0] ord);
    cfg_write(REG_NUM_DIMS, nd);
    cfg_write(REG_SIZE_DIM0, e0);
    cfg_write(REG_SIZE_DIM1, e1);
    cfg_write(REG_SIZE_DIM2, e2);
    cfg_write(REG_SIZE_DIM3, e3);
    cfg_write(REG_DIM_ORDER, ord);
  endtask

  // Random coordinates mostly within the grid, sometimes anywhere up to 255.
  function automatic logic [31:0] rand_coords();
    logic [31:0] c;
    for (int k = 0; k < 4; k++)
      c[8*k +: 8] = ($urandom_range(3) == 0 || grid_sb.extent[k] == 0) ?
                    8'($urandom_range(255)) : 8'($urandom_range(grid_sb.extent[k] - 1));
    return c;
  endfunction

  // Random rank: often inside the grid product, else any 32-bit value.
  function automatic logic [31:0] rand_rank();
    longint prod = 1;
    for (int k = 0; k < 4; k++) prod *= (grid_sb.extent[k] == 0) ? 1 : grid_sb.extent[k];
    if ($urandom_range(1) == 0 && prod <= 64'hFFFF_FFFF)
      return 32'($urandom() % prod);
    return $urandom();
  endfunction

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++) begin
      // hold a quiet stretch in the middle of each phase
      idle_en = !(i >= count / 3 && i < count / 2);
      if ($urandom_range(1)) send_word(ACT_TO_RANK, {rand_coords(), $urandom()});
      else send_word(ACT_TO_COORD, {$urandom(), rand_rank()});
    end
    idle_en = 1'b1;
  endtask

  initial begin
    logic [7:0] ord;
    int         p[4];
    grid_sb      = new();
    grid_sb.reset_grid();
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = 1'b0;
    out_tready   = 1'b0;
    cfg_psel     = 1'b0;
    cfg_penable  = 1'b0;
    cfg_pwrite   = 1'b0;
    cfg_paddr    = '0;
    cfg_pwdata   = '0;
    idle_en      = 1'b1;
    sink_done    = 1'b0;
    quiet_cycles = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: reset grid, then extremes of fields and settings.
    send_word(ACT_TO_COORD, 64'hFFFF_FFFF);
    send_word(ACT_TO_RANK, 64'hFEFE_FEFE_0000_0000);
    drain();
    set_grid(4, 255, 255, 255, 255, 8'd228);
    send_word(ACT_TO_COORD, 64'hFFFF_FFFF);
    send_word(ACT_TO_COORD, 64'h0);
    send_word(ACT_TO_RANK, 64'hFEFE_FEFE_0000_0000);   // largest rank in the grid, 255^4 - 1
    send_word(ACT_TO_RANK, 64'hFFFF_FFFF_FFFF_FFFF);
    drain();
    // dimension count zero, then above four; an extent of zero
    set_grid(0, 0, 7, 3, 5, 8'h1B);
    send_word(ACT_TO_COORD, 64'h1234_5678);
    send_word(ACT_TO_RANK, 64'h0102_0304_0000_0000);
    drain();
    cfg_write(REG_NUM_DIMS, 7);
    send_word(ACT_TO_COORD, 64'hDEAD_BEEF);
    send_word(ACT_TO_RANK, 64'h0402_0601_0000_0000);
    drain();
    // order naming one dimension twice
    set_grid(3, 3, 4, 5, 6, 8'b00_01_00_10);
    send_word(ACT_TO_COORD, 64'd59);
    send_word(ACT_TO_RANK, 64'h0504_0302_0000_0000);
    drain();

    for (int ph = 0; ph < 9; ph++) begin
      ord = 8'($urandom());
      if (ph % 3 != 2) begin
        // most phases use a true permutation
        p = '{0, 1, 2, 3};
        p.shuffle();
        ord = {2'(p[3]), 2'(p[2]), 2'(p[1]), 2'(p[0])};
      end
      if (ph == 0) set_grid(4, 255, 255, 255, 255, ord);
      else if (ph == 1) set_grid(1, 1, 1, 1, 1, ord);
      else set_grid($urandom_range(1, 7), $urandom_range(0, 255), $urandom_range(1, 20),
                    $urandom_range(1, 255), $urandom_range(0, 9), ord);
      random_phase(150);
      drain();
    end

    sink_done = 1'b1;
    repeat (LATENCY) @(posedge clk);
    if (grid_sb.errors == 0 && grid_sb.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
